// ===== rtl/qrs_pkg.sv =====
// qrs_pkg: shared constants and the case code type for the quadratic root solver
// no dependencies; compiled before the interfaces and the solver
package qrs_pkg;

	localparam int DEF_COEF_WIDTH = 32;
	localparam int DEF_FRAC_BITS  = 16;

	typedef enum logic [1:0] {
		CASE_TWO_ROOTS = 2'd0,
		CASE_REPEATED  = 2'd1,
		CASE_LINEAR    = 2'd2,
		CASE_DIV_ZERO  = 2'd3
	} case_code_t;

endpackage

// ===== rtl/qrs_coef_if.sv =====
// qrs_coef_if: valid/ready channel carrying one coefficient set per beat
// depends on qrs_pkg for the default coefficient width
interface qrs_coef_if import qrs_pkg::*; #(
	parameter int COEF_WIDTH = DEF_COEF_WIDTH
);
	logic                         valid;
	logic                         ready;
	logic signed [COEF_WIDTH-1:0] coef_a;
	logic signed [COEF_WIDTH-1:0] coef_b;
	logic signed [COEF_WIDTH-1:0] coef_c;

	modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
	modport sink (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

// ===== rtl/qrs_root_if.sv =====
// qrs_root_if: valid/ready channel carrying one root result per beat
// depends on qrs_pkg for the default coefficient width
interface qrs_root_if import qrs_pkg::*; #(
	parameter int COEF_WIDTH = DEF_COEF_WIDTH
);
	logic                         valid;
	logic                         ready;
	logic signed [COEF_WIDTH-1:0] root;
	logic        [1:0]            case_code;
	logic                         saturated;

	modport source (output valid, output root, output case_code, output saturated, input ready);
	modport sink (input valid, input root, input case_code, input saturated, output ready);
endinterface

// ===== rtl/quadratic_root_solver.sv =====
// quadratic_root_solver: pipelined fixed-point solver for the upper root of a*x*x+b*x+c
// depends on qrs_pkg, qrs_coef_if and qrs_root_if
//
// channel  | interface    | dir | payload
// ---------+--------------+-----+------------------------------------------
// coef     | qrs_coef_if  | in  | coef_a, coef_b, coef_c (signed Qm.FRAC_BITS)
// result   | qrs_root_if  | out | root (signed, saturated), case_code, saturated
//
// one coefficient set enters per cycle unless the output stalls; the square root and
// divider are chains that resolve one result bit per stage
// the last stage is the output register; when it holds a beat that is not taken the
// whole pipeline freezes, and coef.ready drops in the same cycle, so nothing is lost
// arst_n clears only the stage valid bits; data registers load without reset
module quadratic_root_solver import qrs_pkg::*; #(
	parameter int COEF_WIDTH = DEF_COEF_WIDTH,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	qrs_coef_if.sink   coef,
	qrs_root_if.source result
);

	localparam int W   = COEF_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int LO  = W / 2;            // low half of a multiplier operand
	localparam int HI  = W - LO;           // high half
	localparam int PW  = 2 * W + 1;        // products and discriminant
	localparam int TW  = PW + 2;           // sqrt trial compare width
	localparam int SW  = W + 1;            // square root bits
	localparam int NMW = W + 2;            // numerator magnitude
	localparam int DVW = W + 1;            // divisor magnitude
	localparam int NW  = NMW + F;          // dividend and quotient bits
	localparam int RW  = DVW + 1;          // shifted partial remainder
	localparam int NST = 4 + SW + 1 + NW + 1;

	// stage valid bits, oldest at the top
	logic [NST-1:0] vld_q;
	logic           adv;

	assign adv        = !vld_q[NST-1] || result.ready;
	assign coef.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], coef.valid};
		end
	end

	// ---------------- stage 1: split into sign and magnitude ----------------
	logic [W-1:0] ua, ub, uc;
	logic         sa_s1, sb_s1, sc_s1;
	logic [W-1:0] ma_s1, mb_s1, mc_s1;

	assign ua = coef.coef_a;
	assign ub = coef.coef_b;
	assign uc = coef.coef_c;

	always_ff @(posedge clk) begin
		if (adv) begin
			sa_s1 <= ua[W-1];
			sb_s1 <= ub[W-1];
			sc_s1 <= uc[W-1];
			ma_s1 <= ua[W-1] ? (~ua + 1'b1) : ua;
			mb_s1 <= ub[W-1] ? (~ub + 1'b1) : ub;
			mc_s1 <= uc[W-1] ? (~uc + 1'b1) : uc;
		end
	end

	// ---------------- stage 2: partial products of b*b and a*c ----------------
	logic [2*LO-1:0]  bll_s2, all_s2;
	logic [W-1:0]     blh_s2, alh_s2, ahl_s2;
	logic [2*HI-1:0]  bhh_s2, ahh_s2;
	logic             sa_s2, sb_s2, sc_s2, az_s2, bz_s2, cz_s2;
	logic [W-1:0]     ma_s2, mb_s2, mc_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			bll_s2 <= (2*LO)'(mb_s1[LO-1:0]) * (2*LO)'(mb_s1[LO-1:0]);
			blh_s2 <= W'(mb_s1[LO-1:0]) * W'(mb_s1[W-1:LO]);
			bhh_s2 <= (2*HI)'(mb_s1[W-1:LO]) * (2*HI)'(mb_s1[W-1:LO]);
			all_s2 <= (2*LO)'(ma_s1[LO-1:0]) * (2*LO)'(mc_s1[LO-1:0]);
			alh_s2 <= W'(ma_s1[LO-1:0]) * W'(mc_s1[W-1:LO]);
			ahl_s2 <= W'(ma_s1[W-1:LO]) * W'(mc_s1[LO-1:0]);
			ahh_s2 <= (2*HI)'(ma_s1[W-1:LO]) * (2*HI)'(mc_s1[W-1:LO]);
			sa_s2  <= sa_s1;
			sb_s2  <= sb_s1;
			sc_s2  <= sc_s1;
			az_s2  <= (ma_s1 == '0);
			bz_s2  <= (mb_s1 == '0);
			cz_s2  <= (mc_s1 == '0);
			ma_s2  <= ma_s1;
			mb_s2  <= mb_s1;
			mc_s2  <= mc_s1;
		end
	end

	// ---------------- stage 3: sum the partial products ----------------
	logic [PW-1:0] bb_s3, ac4_s3;
	logic          sa_s3, sb_s3, sc_s3, az_s3, bz_s3, cz_s3, acneg_s3;
	logic [W-1:0]  ma_s3, mb_s3, mc_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			bb_s3    <= (PW'(bhh_s2) << (2*LO)) + (PW'(blh_s2) << (LO + 1)) + PW'(bll_s2);
			ac4_s3   <= ((PW'(ahh_s2) << (2*LO)) + ((PW'(alh_s2) + PW'(ahl_s2)) << LO)
				+ PW'(all_s2)) << 2;
			acneg_s3 <= (sa_s2 ^ sc_s2) && !az_s2 && !cz_s2;
			sa_s3    <= sa_s2;
			sb_s3    <= sb_s2;
			sc_s3    <= sc_s2;
			az_s3    <= az_s2;
			bz_s3    <= bz_s2;
			cz_s3    <= cz_s2;
			ma_s3    <= ma_s2;
			mb_s3    <= mb_s2;
			mc_s3    <= mc_s2;
		end
	end

	// ---------------- stage 4: discriminant, case and operand select ----------------
	logic [PW-1:0] disc_sum, disc_dif, disc_c;
	logic          dpos_c;
	case_code_t    code_c;
	logic          nsign_c, dsign_c;
	logic [W-1:0]  nmag_c;
	logic [DVW-1:0] dmag_c;

	assign disc_sum = bb_s3 + ac4_s3;
	assign disc_dif = bb_s3 - ac4_s3;

	always_comb begin
		if (acneg_s3) begin
			dpos_c = (disc_sum != '0);
			disc_c = disc_sum;
		end else begin
			dpos_c = (bb_s3 > ac4_s3);
			disc_c = dpos_c ? disc_dif : '0;
		end
		if (az_s3) begin
			code_c  = bz_s3 ? CASE_DIV_ZERO : CASE_LINEAR;
			nsign_c = !cz_s3 && !sc_s3;       // sign of -c
			nmag_c  = mc_s3;
			dsign_c = sb_s3;
			dmag_c  = DVW'(mb_s3);
		end else begin
			code_c  = dpos_c ? CASE_TWO_ROOTS : CASE_REPEATED;
			nsign_c = !bz_s3 && !sb_s3;       // sign of -b
			nmag_c  = mb_s3;
			dsign_c = sa_s3;
			dmag_c  = {ma_s3, 1'b0};          // 2a
		end
	end

	logic [PW-1:0]  disc_s4;
	case_code_t     code_s4;
	logic           nsign_s4, dsign_s4;
	logic [W-1:0]   nmag_s4;
	logic [DVW-1:0] dmag_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			disc_s4  <= disc_c;
			code_s4  <= code_c;
			nsign_s4 <= nsign_c;
			dsign_s4 <= dsign_c;
			nmag_s4  <= nmag_c;
			dmag_s4  <= dmag_c;
		end
	end

	// ---------------- square root: one result bit per stage ----------------
	logic [PW-1:0]  sqrt_rem_s   [SW];
	logic [SW-1:0]  sqrt_root_s  [SW];
	case_code_t     sqrt_code_s  [SW];
	logic           sqrt_nsign_s [SW];
	logic           sqrt_dsign_s [SW];
	logic [W-1:0]   sqrt_nmag_s  [SW];
	logic [DVW-1:0] sqrt_dmag_s  [SW];

	for (genvar k = 0; k < SW; k++) begin : g_sqrt
		localparam int BIT = SW - 1 - k;
		logic [PW-1:0]  rem_in;
		logic [SW-1:0]  root_in;
		case_code_t     code_in;
		logic           nsign_in, dsign_in;
		logic [W-1:0]   nmag_in;
		logic [DVW-1:0] dmag_in;
		logic [TW-1:0]  trial;
		logic           take;

		if (k == 0) begin : g_head
			assign rem_in   = disc_s4;
			assign root_in  = '0;
			assign code_in  = code_s4;
			assign nsign_in = nsign_s4;
			assign dsign_in = dsign_s4;
			assign nmag_in  = nmag_s4;
			assign dmag_in  = dmag_s4;
		end else begin : g_link
			assign rem_in   = sqrt_rem_s[k-1];
			assign root_in  = sqrt_root_s[k-1];
			assign code_in  = sqrt_code_s[k-1];
			assign nsign_in = sqrt_nsign_s[k-1];
			assign dsign_in = sqrt_dsign_s[k-1];
			assign nmag_in  = sqrt_nmag_s[k-1];
			assign dmag_in  = sqrt_dmag_s[k-1];
		end

		// (r + 2^i)^2 - r^2 = r*2^(i+1) + 2^(2i)
		assign trial = (TW'(root_in) << (BIT + 1)) + (TW'(1) << (2 * BIT));
		assign take  = (TW'(rem_in) >= trial);

		always_ff @(posedge clk) begin
			if (adv) begin
				sqrt_rem_s[k]   <= take ? PW'(TW'(rem_in) - trial) : rem_in;
				sqrt_root_s[k]  <= take ? (root_in | (SW'(1) << BIT)) : root_in;
				sqrt_code_s[k]  <= code_in;
				sqrt_nsign_s[k] <= nsign_in;
				sqrt_dsign_s[k] <= dsign_in;
				sqrt_nmag_s[k]  <= nmag_in;
				sqrt_dmag_s[k]  <= dmag_in;
			end
		end
	end

	// ---------------- numerator: -b +/- sqrt(d) as sign and magnitude ----------------
	logic [NMW-1:0] nm_c, sm_c, num_c;
	logic           numsign_c;
	case_code_t     code_sq;

	assign code_sq = sqrt_code_s[SW-1];
	assign nm_c    = NMW'(sqrt_nmag_s[SW-1]);
	assign sm_c    = NMW'(sqrt_root_s[SW-1]);

	always_comb begin
		num_c     = nm_c;
		numsign_c = sqrt_nsign_s[SW-1];
		if (code_sq == CASE_TWO_ROOTS) begin
			// the root carries the sign of a, which picks the upper root
			if (sqrt_nsign_s[SW-1] == sqrt_dsign_s[SW-1]) begin
				num_c = nm_c + sm_c;
			end else if (nm_c >= sm_c) begin
				num_c = nm_c - sm_c;
			end else begin
				num_c     = sm_c - nm_c;
				numsign_c = sqrt_dsign_s[SW-1];
			end
		end
	end

	logic [NMW-1:0] num_sn;
	logic           nsign_sn, dsign_sn;
	logic [DVW-1:0] dmag_sn;
	case_code_t     code_sn;

	always_ff @(posedge clk) begin
		if (adv) begin
			num_sn   <= num_c;
			nsign_sn <= numsign_c;
			dsign_sn <= sqrt_dsign_s[SW-1];
			dmag_sn  <= sqrt_dmag_s[SW-1];
			code_sn  <= code_sq;
		end
	end

	// ---------------- divider: restoring, one quotient bit per stage ----------------
	logic [DVW-1:0] div_rem_s   [NW];
	logic [NW-1:0]  div_quo_s   [NW];
	logic [NMW-1:0] div_num_s   [NW];
	logic [DVW-1:0] div_dmag_s  [NW];
	logic           div_nsign_s [NW];
	logic           div_dsign_s [NW];
	case_code_t     div_code_s  [NW];

	for (genvar j = 0; j < NW; j++) begin : g_div
		localparam int POS = NW - 1 - j;
		logic [DVW-1:0] rem_in;
		logic [NW-1:0]  quo_in;
		logic [NMW-1:0] num_in;
		logic [DVW-1:0] dmag_in;
		logic           nsign_in, dsign_in;
		case_code_t     code_in;
		logic           nbit;
		logic [RW-1:0]  rsh;
		logic           take;

		if (j == 0) begin : g_head
			assign rem_in   = '0;
			assign quo_in   = '0;
			assign num_in   = num_sn;
			assign dmag_in  = dmag_sn;
			assign nsign_in = nsign_sn;
			assign dsign_in = dsign_sn;
			assign code_in  = code_sn;
		end else begin : g_link
			assign rem_in   = div_rem_s[j-1];
			assign quo_in   = div_quo_s[j-1];
			assign num_in   = div_num_s[j-1];
			assign dmag_in  = div_dmag_s[j-1];
			assign nsign_in = div_nsign_s[j-1];
			assign dsign_in = div_dsign_s[j-1];
			assign code_in  = div_code_s[j-1];
		end

		// dividend is the numerator shifted up by the fraction bits
		if (POS >= F) begin : g_nbit
			assign nbit = num_in[POS-F];
		end else begin : g_zbit
			assign nbit = 1'b0;
		end

		assign rsh  = {rem_in, nbit};
		assign take = (rsh >= RW'(dmag_in));

		always_ff @(posedge clk) begin
			if (adv) begin
				div_rem_s[j]   <= take ? DVW'(rsh - RW'(dmag_in)) : DVW'(rsh);
				div_quo_s[j]   <= take ? (quo_in | (NW'(1) << POS)) : quo_in;
				div_num_s[j]   <= num_in;
				div_dmag_s[j]  <= dmag_in;
				div_nsign_s[j] <= nsign_in;
				div_dsign_s[j] <= dsign_in;
				div_code_s[j]  <= code_in;
			end
		end
	end

	// ---------------- output stage: sign, saturation, divide-by-zero ----------------
	localparam logic [NW-1:0] HALF = NW'(1) << (W - 1);

	logic [NW-1:0] quo_f;
	logic          neg_f;
	logic [W-1:0]  root_c;
	logic          sat_c;

	assign quo_f = div_quo_s[NW-1];
	assign neg_f = (div_nsign_s[NW-1] ^ div_dsign_s[NW-1]) && (quo_f != '0);

	always_comb begin
		if (div_code_s[NW-1] == CASE_DIV_ZERO) begin
			root_c = '0;
			sat_c  = 1'b0;
		end else if (neg_f) begin
			if (quo_f > HALF) begin
				sat_c  = 1'b1;
				root_c = ~(W'(HALF)) + 1'b1;
			end else begin
				sat_c  = 1'b0;
				root_c = ~(quo_f[W-1:0]) + 1'b1;
			end
		end else if (quo_f > (HALF - 1'b1)) begin
			sat_c  = 1'b1;
			root_c = W'(HALF - 1'b1);
		end else begin
			sat_c  = 1'b0;
			root_c = quo_f[W-1:0];
		end
	end

	logic [W-1:0] root_so;
	logic         sat_so;
	case_code_t   code_so;

	always_ff @(posedge clk) begin
		if (adv) begin
			root_so <= root_c;
			sat_so  <= sat_c;
			code_so <= div_code_s[NW-1];
		end
	end

	assign result.valid     = vld_q[NST-1];
	assign result.root      = root_so;
	assign result.case_code = code_so;
	assign result.saturated = sat_so;

endmodule

// ===== sim/testbench.sv =====
// testbench: randomized check of quadratic_root_solver against a built-in predictor
// depends on qrs_pkg, qrs_coef_if, qrs_root_if and the solver rtl
module testbench import qrs_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW        = DEF_COEF_WIDTH;
	localparam int FB        = DEF_FRAC_BITS;
	localparam int LATENCY   = 2*CW + FB + 9;
	localparam int MAX_CYCLES = 400000;
	localparam int N_RANDOM  = 1900;

	typedef logic signed [CW-1:0] coef_t;

	// one coefficient set; drain asks the driver to wait for an empty pipeline first
	typedef struct {
		coef_t a;
		coef_t b;
		coef_t c;
		bit    drain;
	} coef_set_t;

	typedef struct {
		coef_t      root;
		case_code_t code;
		logic       sat;
	} root_res_t;

	logic clk;
	logic arst_n;
	int   cycle_cnt;
	bit   failed;

	coef_set_t pending_sets[$];
	root_res_t expected_roots[$];

	qrs_coef_if coef_bus();
	qrs_root_if root_bus();

	quadratic_root_solver uut (
		.clk    (clk),
		.arst_n (arst_n),
		.coef   (coef_bus),
		.result (root_bus)
	);

	// exact upper root: wide signed integers, truncating division, then saturation
	function automatic root_res_t solve_root(coef_t a, coef_t b, coef_t c);
		logic signed [127:0] wa, wb, wc, disc, num, den, q, s, cand;
		root_res_t r;
		wa = a;
		wb = b;
		wc = c;
		r.root = '0;
		r.sat  = 1'b0;
		num = '0;
		den = '0;
		if (wa == 0) begin
			if (wb == 0) r.code = CASE_DIV_ZERO;
			else begin
				r.code = CASE_LINEAR;
				num = -wc;
				den = wb;
			end
		end else begin
			disc = wb*wb - 128'sd4*wa*wc;
			den  = 128'sd2*wa;
			if (disc <= 0) begin
				r.code = CASE_REPEATED;
				num = -wb;
			end else begin
				r.code = CASE_TWO_ROOTS;
				// bitwise floor square root, the discriminant stays below 2^68
				s = '0;
				for (int i = 40; i >= 0; i--) begin
					cand = s | (128'sd1 <<< i);
					if (cand*cand <= disc) s = cand;
				end
				// the larger root takes +sqrt for a > 0 and -sqrt for a < 0
				num = (wa > 0) ? -wb + s : -wb - s;
			end
		end
		if (r.code != CASE_DIV_ZERO) begin
			q = (num <<< FB) / den;
			if (q > 128'sd2147483647) begin
				r.root = {1'b0, {(CW-1){1'b1}}};
				r.sat  = 1'b1;
			end else if (q < -128'sd2147483648) begin
				r.root = {1'b1, {(CW-1){1'b0}}};
				r.sat  = 1'b1;
			end else r.root = q[CW-1:0];
		end
		return r;
	endfunction

	// coefficient mix: mostly moderate magnitudes so roots stay in range, plus zeros,
	// extremes and fully random words
	function automatic coef_t pick_coef();
		int unsigned sel;
		coef_t v;
		sel = $urandom_range(0, 9);
		case (sel)
			0: begin
				v = '0;
			end
			1: begin
				v = $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
			end
			2, 3: begin
				v = $urandom;
			end
			4, 5, 6: begin
				v = $urandom_range(0, 32'h0008_0000);
				if ($urandom_range(0, 1)) v = -v;
			end
			default: begin
				v = $urandom_range(0, 32'h0100_0000);
				if ($urandom_range(0, 1)) v = -v;
			end
		endcase
		return v;
	endfunction

	task automatic add_set(coef_t a, coef_t b, coef_t c, bit drain = 1'b0);
		coef_set_t s;
		s.a = a;
		s.b = b;
		s.c = c;
		s.drain = drain;
		pending_sets.push_back(s);
	endtask

	// random idling on both sides, except in one long window with no idling
	function automatic bit take_idle();
		if (cycle_cnt > 2000 && cycle_cnt < 2600) return 1'b0;
		return $urandom_range(0, 99) < 25;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= MAX_CYCLES) begin
			$display("%0t: timeout, %0d sets pending, %0d roots outstanding",
				$time, pending_sets.size(), expected_roots.size());
			$display("quadratic_root_solver test failed");
			$finish;
		end
	end

	// driver: on each accepted beat predict the root, then present the next set
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_bus.valid  <= 1'b0;
			coef_bus.coef_a <= '0;
			coef_bus.coef_b <= '0;
			coef_bus.coef_c <= '0;
		end else begin
			if (coef_bus.valid && coef_bus.ready) begin
				expected_roots.push_back(solve_root(coef_bus.coef_a, coef_bus.coef_b,
					coef_bus.coef_c));
				void'(pending_sets.pop_front());
			end
			if (coef_bus.valid && !coef_bus.ready) begin
				// a waiting beat stays on the bus unchanged
			end else if (pending_sets.size() == 0 || take_idle() ||
				(pending_sets[0].drain && expected_roots.size() != 0) ||
				(pending_sets[0].drain && coef_bus.valid && coef_bus.ready)) begin
				coef_bus.valid <= 1'b0;
			end else begin
				coef_bus.valid  <= 1'b1;
				coef_bus.coef_a <= pending_sets[0].a;
				coef_bus.coef_b <= pending_sets[0].b;
				coef_bus.coef_c <= pending_sets[0].c;
			end
		end
	end

	// monitor: random backpressure, each result beat against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_bus.ready <= 1'b0;
		end else begin
			if (root_bus.valid && root_bus.ready) begin
				if (expected_roots.size() == 0) begin
					$display("%0t: unexpected result beat root=%h code=%0d sat=%b", $time,
						root_bus.root, root_bus.case_code, root_bus.saturated);
					failed = 1'b1;
				end else begin
					root_res_t e;
					e = expected_roots.pop_front();
					if (root_bus.root !== e.root) begin
						$display("%0t: root mismatch expected %h actual %h",
							$time, e.root, root_bus.root);
						failed = 1'b1;
					end
					if (root_bus.case_code !== e.code) begin
						$display("%0t: case_code mismatch expected %0d actual %0d",
							$time, e.code, root_bus.case_code);
						failed = 1'b1;
					end
					if (root_bus.saturated !== e.sat) begin
						$display("%0t: saturated mismatch expected %b actual %b",
							$time, e.sat, root_bus.saturated);
						failed = 1'b1;
					end
				end
			end
			root_bus.ready <= !take_idle();
		end
	end

	initial begin
		coef_t one;
		cycle_cnt = 0;
		failed    = 1'b0;
		one = 1 << FB;
		// all zero and a = b = 0: divide by zero
		add_set('0, '0, '0);
		add_set('0, '0, 5 * one);
		// linear, plain and saturating both ways
		add_set('0, 2 * one, -6 * one);
		add_set('0, 1, 32'h7fff_ffff);
		add_set('0, 1, 32'h8000_0000);
		add_set('0, 32'h8000_0000, 32'h7fff_ffff);
		// repeated root and complex pair
		add_set(one, 2 * one, one);
		add_set(one, '0, 4 * one);
		add_set(-one, 3 * one, -5 * one);
		// two real roots with a positive and negative, b zero
		add_set(one, -3 * one, 2 * one);
		add_set(-one, one, 6 * one);
		add_set(one, '0, -4 * one);
		// extremes of every field
		add_set(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		add_set(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_set(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
		add_set(1, 32'h8000_0000, 32'h8000_0000);
		add_set(1, '0, 32'h8000_0000);
		add_set(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		// random part; one set mid-way waits for an empty pipeline
		for (int i = 0; i < N_RANDOM; i++)
			add_set(pick_coef(), pick_coef(), pick_coef(), i == N_RANDOM / 2);
		wait (arst_n === 1'b1);
		wait (pending_sets.size() == 0);
		wait (expected_roots.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (!failed && expected_roots.size() == 0) begin
			$display("quadratic_root_solver test passed");
		end else begin
			$display("quadratic_root_solver test failed");
		end
		$finish;
	end
endmodule

// ===== quadratic_root_solver.f =====
rtl/qrs_pkg.sv
rtl/qrs_coef_if.sv
rtl/qrs_root_if.sv
rtl/quadratic_root_solver.sv
sim/testbench.sv
